FILE: src/trial_division_prime_test_defines.svh
// assertion macros for the trial division prime tester
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// property that must hold in the same cycle
`define TDPT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tdpt assertion failed");

// consequence that must hold in the cycle after the antecedent
`define TDPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tdpt assertion failed");

`endif

FILE: src/tdpt_pkg.sv
// shared types and constants of the trial division prime tester
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

  // width of the running prime count
  localparam int unsigned COUNT_WIDTH = 27;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIV    = 4'b0010,
    ST_EVAL   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

endpackage

`default_nettype wire

FILE: src/trial_division_prime_test.sv
// top level of the trial division prime tester: sequencer and shared divider
// depends on tdpt_pkg and trial_division_prime_test_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "trial_division_prime_test_defines.svh"

// Tests one unsigned candidate per input beat for primality by trial division and returns
// one result beat: the prime flag and the count of primes seen since reset (wrapping at
// 2^27). Candidates below four and even candidates are decided without the divider. Odd
// candidates of five and up go through one shared restoring radix-2 divider that gives
// both n / d and n % d for each odd divisor d = 3, 5, 7, ...; each divisor takes
// VALUE_WIDTH divide steps plus one evaluation step, and the quotient gives the exact
// bound d <= n / d. A prime near 2^31 thus needs about 23170 divisors. The input stalls
// while a candidate is under test or its result waits for the output register; a
// finished result sits in the output register, so the next candidate is taken while it
// waits to be collected.
module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 31
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [VALUE_WIDTH-1:0] candidate_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        is_prime_o,
  output logic [COUNT_WIDTH-1:0]      primes_so_far_o
);

  localparam int unsigned CntWidth = $clog2(VALUE_WIDTH);

  state_e                  state_q, state_d;
  logic [VALUE_WIDTH-1:0]  n_q, n_d;
  logic [VALUE_WIDTH-1:0]  div_q, div_d;
  logic [VALUE_WIDTH-1:0]  quo_q, quo_d;
  logic [VALUE_WIDTH-1:0]  rem_q, rem_d;
  logic [VALUE_WIDTH-1:0]  dvd_q, dvd_d;
  logic [CntWidth-1:0]     cnt_q, cnt_d;
  logic                    prime_q, prime_d;
  logic                    out_valid_q, out_valid_d;
  logic                    is_prime_q, is_prime_d;
  logic [COUNT_WIDTH-1:0]  count_q, count_d;

  logic                    in_beat;
  logic                    load_out;
  logic [VALUE_WIDTH:0]    rem_sh;
  logic [VALUE_WIDTH:0]    rem_sub;
  logic                    ge;

  assign in_beat = in_valid_i && !in_stall_o;

  // one restoring divide step: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_q, dvd_q[VALUE_WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign ge      = !rem_sub[VALUE_WIDTH];

  // result register is free when empty or being collected this cycle
  assign load_out = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    div_d   = div_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    cnt_d   = cnt_q;
    prime_d = prime_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          n_d   = candidate_i;
          div_d = VALUE_WIDTH'(3);
          quo_d = '0;
          rem_d = '0;
          dvd_d = candidate_i;
          cnt_d = '0;
          priority if (candidate_i[VALUE_WIDTH-1:1] == '0) begin
            // zero or one
            prime_d = 1'b0;
            state_d = ST_FINISH;
          end else if (candidate_i[VALUE_WIDTH-1:2] == '0) begin
            // two or three
            prime_d = 1'b1;
            state_d = ST_FINISH;
          end else if (!candidate_i[0]) begin
            // even and above two
            prime_d = 1'b0;
            state_d = ST_FINISH;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d = ge ? rem_sub[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
        quo_d = {quo_q[VALUE_WIDTH-2:0], ge};
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + CntWidth'(1);
        if (cnt_q == CntWidth'(VALUE_WIDTH - 1)) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        priority if (div_q > quo_q) begin
          // divisor passed the square root bound
          prime_d = 1'b1;
          state_d = ST_FINISH;
        end else if (rem_q == '0) begin
          prime_d = 1'b0;
          state_d = ST_FINISH;
        end else begin
          // next odd divisor
          div_d   = div_q + VALUE_WIDTH'(2);
          quo_d   = '0;
          rem_d   = '0;
          dvd_d   = n_q;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result register and running prime count
  always_comb begin
    out_valid_d = out_valid_q;
    is_prime_d  = is_prime_q;
    count_d     = count_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      is_prime_d  = prime_q;
      count_d     = prime_q ? count_q + COUNT_WIDTH'(1) : count_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      cnt_q       <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    div_q      <= div_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    prime_q    <= prime_d;
    is_prime_q <= is_prime_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign is_prime_o      = is_prime_q;
  assign primes_so_far_o = count_q;

  // checks
  `TDPT_ASSERT(div_odd_a, (state_q == ST_DIV) |-> div_q[0])
  `TDPT_ASSERT(rem_below_div_a,
      ((state_q == ST_DIV) || (state_q == ST_EVAL)) |-> (rem_q < div_q))
  `TDPT_ASSERT_NEXT(count_step_a, load_out,
      (primes_so_far_o ==
       ($past(prime_q) ? $past(count_q) + COUNT_WIDTH'(1) : $past(count_q))))

endmodule

`default_nettype wire
